/* rtl/core/vn2_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// vn2_pkg
// shared types and constants for the 2d value noise pipeline
// ============================================================================
package vn2_pkg;

    localparam int GRID_SIDE_DEF = 256;
    localparam int TABLE_DEPTH   = 65536;
    localparam int TABLE_AW      = 16;
    localparam int VAL_W         = 16;
    localparam int POINT_W       = 32;
    localparam int FRAC_W        = 16;
    localparam int EASE_W        = 17;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_EVAL  = 1'b1
    } cmd_t;

    // lattice write carried down to the memory stage
    typedef struct packed {
        logic                en;
        logic [TABLE_AW-1:0] index;
        logic [VAL_W-1:0]    value;
    } wr_req_t;

    // four corner values of one lattice cell
    typedef struct packed {
        logic [VAL_W-1:0] c00;
        logic [VAL_W-1:0] c10;
        logic [VAL_W-1:0] c01;
        logic [VAL_W-1:0] c11;
    } corners_t;

endpackage

/* rtl/core/value_noise_2d.sv */
`timescale 1ns / 1ps
// ============================================================================
// value_noise_2d
// two-dimensional value noise with smoothstep easing and bilinear blend
// ============================================================================
// One transaction enters per clock while item_ready is high, and the pipeline
// holds up to nine of them. A write transaction (cmd = 0) stores entry_value
// at entry_index of the 65536-entry lattice table and returns nothing; an
// evaluate transaction (cmd = 1) passes down the pipeline and raises
// noise_valid when it reaches the result register (stage 9). Throughput is
// one transaction per cycle while noise_ready does not stall the pipe, set by
// the lattice memory, which is kept as two identical banks so that all four
// cell corners are read in the single memory stage (stage 5). Writes land in
// that same stage in arrival order, so an evaluate placed right after a write
// sees the new value. The table has no reset: every entry an evaluate touches
// must have been written first. Backpressure on noise_ready collapses bubbles
// stage by stage, so item_ready stays high while any stage is empty.
// ============================================================================
module value_noise_2d #(
    parameter int GRID_SIDE = vn2_pkg::GRID_SIDE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic                               cmd,
    input  logic [vn2_pkg::TABLE_AW-1:0]       entry_index,
    input  logic [vn2_pkg::VAL_W-1:0]          entry_value,
    input  logic signed [vn2_pkg::POINT_W-1:0] point_x,
    input  logic signed [vn2_pkg::POINT_W-1:0] point_y,
    output logic                               noise_valid,
    input  logic                               noise_ready,
    output logic [vn2_pkg::VAL_W-1:0]          noise_value
);
    import vn2_pkg::*;

    localparam int CW       = $clog2(GRID_SIDE);
    localparam int N_STAGES = 9;
    localparam int ST_ADDR  = 4;    // corner addresses and eased fractions ready
    localparam int ST_MEM   = 5;    // lattice read and write
    localparam int ST_XLERP = 7;    // both x blends done
    localparam int ST_OUT   = 9;    // result register

    // write transaction fields carried down to the memory stage
    typedef struct packed {
        logic                cmd;
        logic [TABLE_AW-1:0] index;
        logic [VAL_W-1:0]    value;
    } item_hdr_t;

    logic [N_STAGES:1] valid_reg;
    logic [N_STAGES:1] valid_next;
    logic [N_STAGES:1] load;

    item_hdr_t          hdr_reg [1:ST_ADDR];
    logic [POINT_W-1:0] px_reg;
    logic [POINT_W-1:0] py_reg;

    logic [CW-1:0]     cell_x;
    logic [CW-1:0]     cell_y;
    logic [EASE_W-1:0] sx;
    logic [EASE_W-1:0] sy;
    logic [EASE_W-1:0] sx_mem_reg;
    logic [EASE_W-1:0] sy_mem_reg;
    logic [EASE_W-1:0] sy_p6_reg;
    logic [EASE_W-1:0] sy_p7_reg;

    wr_req_t          wr_req;
    corners_t         corners;
    logic [VAL_W-1:0] row0_val;
    logic [VAL_W-1:0] row1_val;

    // ------------------------------------------------------------------
    // flow control: a stage loads when it is empty or its successor loads
    // ------------------------------------------------------------------
    always_comb
    begin
        load[N_STAGES] = !valid_reg[N_STAGES] || noise_ready;
        for (int i = N_STAGES - 1; i >= 1; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    assign item_ready = load[1];

    always_comb
    begin
        valid_next = valid_reg;
        if (load[1])
        begin
            valid_next[1] = item_valid;
        end
        for (int i = 2; i <= N_STAGES; i++)
        begin
            if (load[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
        // write transactions end at the memory stage
        if (load[ST_MEM])
        begin
            valid_next[ST_MEM] = valid_reg[ST_MEM-1] && (hdr_reg[ST_ADDR].cmd == CMD_EVAL);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // ------------------------------------------------------------------
    // input stage and header pipeline
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            hdr_reg[1] <= '{cmd: cmd, index: entry_index, value: entry_value};
            px_reg     <= point_x;
            py_reg     <= point_y;
        end
        for (int i = 2; i <= ST_ADDR; i++)
        begin
            if (load[i])
            begin
                hdr_reg[i] <= hdr_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // cell coordinates (stages 2-3) and eased fractions (stages 2-4)
    // ------------------------------------------------------------------
    vn2_wrap #(
        .GRID_SIDE (GRID_SIDE)
    ) u_wrap_x (
        .clk      (clk),
        .load_a   (load[2]),
        .load_b   (load[3]),
        .ipart    (px_reg[POINT_W-1:FRAC_W]),
        .cell_idx (cell_x)
    );

    vn2_wrap #(
        .GRID_SIDE (GRID_SIDE)
    ) u_wrap_y (
        .clk      (clk),
        .load_a   (load[2]),
        .load_b   (load[3]),
        .ipart    (py_reg[POINT_W-1:FRAC_W]),
        .cell_idx (cell_y)
    );

    vn2_ease u_ease_x (
        .clk    (clk),
        .load_a (load[2]),
        .load_b (load[3]),
        .load_c (load[ST_ADDR]),
        .frac   (px_reg[FRAC_W-1:0]),
        .eased  (sx)
    );

    vn2_ease u_ease_y (
        .clk    (clk),
        .load_a (load[2]),
        .load_b (load[3]),
        .load_c (load[ST_ADDR]),
        .frac   (py_reg[FRAC_W-1:0]),
        .eased  (sy)
    );

    // ------------------------------------------------------------------
    // lattice: addresses in stage 4, read or write in stage 5
    // ------------------------------------------------------------------
    assign wr_req.en    = valid_reg[ST_ADDR] && (hdr_reg[ST_ADDR].cmd == CMD_WRITE)
                          && load[ST_MEM];
    assign wr_req.index = hdr_reg[ST_ADDR].index;
    assign wr_req.value = hdr_reg[ST_ADDR].value;

    vn2_lattice #(
        .GRID_SIDE (GRID_SIDE)
    ) u_lattice (
        .clk       (clk),
        .load_addr (load[ST_ADDR]),
        .load_rd   (load[ST_MEM]),
        .cell_x    (cell_x),
        .cell_y    (cell_y),
        .wr_req    (wr_req),
        .corners   (corners)
    );

    // eased weights follow the corners down the pipe
    always_ff @(posedge clk)
    begin
        if (load[ST_MEM])
        begin
            sx_mem_reg <= sx;
            sy_mem_reg <= sy;
        end
        if (load[6])
        begin
            sy_p6_reg <= sy_mem_reg;
        end
        if (load[ST_XLERP])
        begin
            sy_p7_reg <= sy_p6_reg;
        end
    end

    // ------------------------------------------------------------------
    // bilinear blend: x blends in stages 6-7, y blend in stages 8-9
    // ------------------------------------------------------------------
    vn2_lerp u_lerp_row0 (
        .clk     (clk),
        .load_a  (load[6]),
        .load_b  (load[ST_XLERP]),
        .val_a   (corners.c00),
        .val_b   (corners.c10),
        .wgt     (sx_mem_reg),
        .blended (row0_val)
    );

    vn2_lerp u_lerp_row1 (
        .clk     (clk),
        .load_a  (load[6]),
        .load_b  (load[ST_XLERP]),
        .val_a   (corners.c01),
        .val_b   (corners.c11),
        .wgt     (sx_mem_reg),
        .blended (row1_val)
    );

    // the last blend register doubles as the output register
    vn2_lerp u_lerp_col (
        .clk     (clk),
        .load_a  (load[8]),
        .load_b  (load[ST_OUT]),
        .val_a   (row0_val),
        .val_b   (row1_val),
        .wgt     (sy_p7_reg),
        .blended (noise_value)
    );

    assign noise_valid = valid_reg[ST_OUT];

endmodule

/* rtl/core/vn2_wrap.sv */
`timescale 1ns / 1ps
// ============================================================================
// vn2_wrap
// two-stage floor modulo of a signed 16-bit integer part by the grid side
// ============================================================================
module vn2_wrap #(
    parameter int GRID_SIDE = vn2_pkg::GRID_SIDE_DEF
) (
    input  logic                          clk,
    input  logic                          load_a,
    input  logic                          load_b,
    input  logic [15:0]                   ipart,
    output logic [$clog2(GRID_SIDE)-1:0]  cell_idx
);
    import vn2_pkg::*;

    localparam int          CW     = $clog2(GRID_SIDE);
    localparam logic [31:0] RECIP  = 32'((64'd1 << 32) / GRID_SIDE);
    localparam int          OFF    = 32768 % GRID_SIDE;
    localparam logic [CW:0] SIDE_R = (CW+1)'(GRID_SIDE);
    localparam logic [CW:0] OFF_R  = (CW+1)'(OFF);
    localparam logic [31:0] SIDE_W = 32'(GRID_SIDE);

    logic [15:0]   biased;
    logic [47:0]   quot_prod;
    logic [15:0]   quot_reg;
    logic [15:0]   biased_reg;
    logic [31:0]   rem_full;
    logic [CW:0]   rem;
    logic [CW:0]   rem_red;
    logic [CW:0]   cell_next;
    logic [CW-1:0] cell_reg;

    // bias by 2^15 so the dividend is unsigned
    assign biased    = {~ipart[15], ipart[14:0]};
    assign quot_prod = 48'(biased) * 48'(RECIP);

    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            quot_reg   <= quot_prod[47:32];
            biased_reg <= biased;
        end
    end

    // quotient estimate is exact or one low, so remainder is below twice the side
    always_comb
    begin
        rem_full = {16'b0, biased_reg} - 32'(quot_reg) * SIDE_W;
        rem      = rem_full[CW:0];
        rem_red  = (rem >= SIDE_R) ? (rem - SIDE_R) : rem;
        // remove the bias modulo the side
        if (rem_red >= OFF_R)
        begin
            cell_next = rem_red - OFF_R;
        end
        else
        begin
            cell_next = rem_red + SIDE_R - OFF_R;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_b)
        begin
            cell_reg <= cell_next[CW-1:0];
        end
    end

    assign cell_idx = cell_reg;

endmodule

/* rtl/core/vn2_ease.sv */
`timescale 1ns / 1ps
// ============================================================================
// vn2_ease
// three-stage smoothstep 3t^2-2t^3 of a q0.16 fraction, rounded to q1.16
// ============================================================================
module vn2_ease (
    input  logic                       clk,
    input  logic                       load_a,
    input  logic                       load_b,
    input  logic                       load_c,
    input  logic [vn2_pkg::FRAC_W-1:0] frac,
    output logic [vn2_pkg::EASE_W-1:0] eased
);
    import vn2_pkg::*;

    localparam logic [17:0] EASE_K = 18'd196608;
    localparam logic [50:0] ROUND  = 51'h0_8000_0000;

    logic [31:0]       sq_reg;
    logic [17:0]       wgt_reg;
    logic [49:0]       prod_reg;
    logic [50:0]       rounded;
    logic [EASE_W-1:0] eased_reg;

    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            sq_reg  <= 32'(frac) * 32'(frac);
            wgt_reg <= EASE_K - 18'({frac, 1'b0});
        end
        if (load_b)
        begin
            prod_reg <= 50'(sq_reg) * 50'(wgt_reg);
        end
        if (load_c)
        begin
            eased_reg <= rounded[48:32];
        end
    end

    assign rounded = 51'(prod_reg) + ROUND;
    assign eased   = eased_reg;

endmodule

/* rtl/core/vn2_lerp.sv */
`timescale 1ns / 1ps
// ============================================================================
// vn2_lerp
// two-stage linear blend of two q0.16 values, rounded half up and clamped
// ============================================================================
module vn2_lerp (
    input  logic                       clk,
    input  logic                       load_a,
    input  logic                       load_b,
    input  logic [vn2_pkg::VAL_W-1:0]  val_a,
    input  logic [vn2_pkg::VAL_W-1:0]  val_b,
    input  logic [vn2_pkg::EASE_W-1:0] wgt,
    output logic [vn2_pkg::VAL_W-1:0]  blended
);
    import vn2_pkg::*;

    localparam logic [EASE_W-1:0] ONE_Q16 = 17'h1_0000;

    logic [32:0]      prod_a_reg;
    logic [32:0]      prod_b_reg;
    logic [33:0]      sum;
    logic [VAL_W-1:0] blended_reg;

    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            prod_a_reg <= 33'(val_a) * 33'(ONE_Q16 - wgt);
            prod_b_reg <= 33'(val_b) * 33'(wgt);
        end
        if (load_b)
        begin
            blended_reg <= (sum[33:16] > 18'd65535) ? 16'hFFFF : sum[31:16];
        end
    end

    assign sum     = 34'(prod_a_reg) + 34'(prod_b_reg) + 34'd32768;
    assign blended = blended_reg;

endmodule

/* rtl/core/vn2_lattice.sv */
`timescale 1ns / 1ps
// ============================================================================
// vn2_lattice
// corner address generation and the lattice table, two banks of two read ports
// ============================================================================
module vn2_lattice #(
    parameter int GRID_SIDE = vn2_pkg::GRID_SIDE_DEF
) (
    input  logic                         clk,
    input  logic                         load_addr,
    input  logic                         load_rd,
    input  logic [$clog2(GRID_SIDE)-1:0] cell_x,
    input  logic [$clog2(GRID_SIDE)-1:0] cell_y,
    input  vn2_pkg::wr_req_t             wr_req,
    output vn2_pkg::corners_t            corners
);
    import vn2_pkg::*;

    localparam int            CW      = $clog2(GRID_SIDE);
    localparam logic [CW-1:0] LAST_C  = CW'(GRID_SIDE - 1);
    localparam logic [31:0]   SIDE_W  = 32'(GRID_SIDE);

    logic [CW-1:0]       cx1;
    logic [CW-1:0]       cy1;
    logic [31:0]         row0;
    logic [31:0]         row1;
    logic [TABLE_AW-1:0] addr00_reg;
    logic [TABLE_AW-1:0] addr10_reg;
    logic [TABLE_AW-1:0] addr01_reg;
    logic [TABLE_AW-1:0] addr11_reg;
    corners_t            corners_reg;

    // identical copies: bank_a serves the lower row, bank_b the upper row
    logic [VAL_W-1:0] bank_a [TABLE_DEPTH];
    logic [VAL_W-1:0] bank_b [TABLE_DEPTH];

    assign cx1  = (cell_x == LAST_C) ? '0 : cell_x + CW'(1);
    assign cy1  = (cell_y == LAST_C) ? '0 : cell_y + CW'(1);
    assign row0 = 32'(cell_y) * SIDE_W;
    assign row1 = 32'(cy1) * SIDE_W;

    // addresses wrap modulo the table depth
    always_ff @(posedge clk)
    begin
        if (load_addr)
        begin
            addr00_reg <= TABLE_AW'(row0 + 32'(cell_x));
            addr10_reg <= TABLE_AW'(row0 + 32'(cx1));
            addr01_reg <= TABLE_AW'(row1 + 32'(cell_x));
            addr11_reg <= TABLE_AW'(row1 + 32'(cx1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_req.en)
        begin
            bank_a[wr_req.index] <= wr_req.value;
            bank_b[wr_req.index] <= wr_req.value;
        end
        if (load_rd)
        begin
            corners_reg.c00 <= bank_a[addr00_reg];
            corners_reg.c10 <= bank_a[addr10_reg];
            corners_reg.c01 <= bank_b[addr01_reg];
            corners_reg.c11 <= bank_b[addr11_reg];
        end
    end

    assign corners = corners_reg;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ============================================================================
// testbench
// self-checking bench for the 2d value noise pipeline
// ============================================================================
// Lattice writes and evaluate transactions go in through the item channel, and
// a scoreboard predicts every noise value in fixed point. Each evaluate point
// only touches lattice entries that were written before it. The run starts
// with a short directed part: value and index extremes, fraction extremes,
// negative and wrapping coordinates, and a write followed at once by a read.
// Random traffic follows in phases with different sender idling and receiver
// stalling.
// ============================================================================
module testbench;

    import vn2_pkg::*;

    localparam int GRID = GRID_SIDE_DEF;

    // ------------------------------------------------------------------------
    // scoreboard: lattice shadow, written map, queue of expected noise values
    // ------------------------------------------------------------------------
    class noise_scoreboard;
        logic [VAL_W-1:0] lattice [TABLE_DEPTH];
        bit               written [TABLE_DEPTH];
        logic [VAL_W-1:0] expected_noise [$];
        int               errors;

        function new();
            errors = 0;
        endfunction

        // table address of one cell corner; bit 0 of k steps x, bit 1 steps y
        function logic [TABLE_AW-1:0] corner_addr(logic [31:0] px, logic [31:0] py,
                                                  int k);
            int xi;
            int yi;
            int cx;
            int cy;
            xi = $signed(px[31:16]);
            yi = $signed(py[31:16]);
            cx = xi % GRID;
            if (cx < 0) cx += GRID;
            cy = yi % GRID;
            if (cy < 0) cy += GRID;
            if (k[0]) cx = (cx + 1) % GRID;
            if (k[1]) cy = (cy + 1) % GRID;
            return TABLE_AW'(cy * GRID + cx);
        endfunction

        // smoothstep of a q0.16 fraction, rounded half up to 17 bits
        function logic [EASE_W-1:0] ease_frac(logic [FRAC_W-1:0] t);
            logic [63:0] p;
            p = 64'(t) * 64'(t) * (64'd196608 - 64'(t) * 64'd2);
            return EASE_W'((p + 64'h8000_0000) >> 32);
        endfunction

        function logic [VAL_W-1:0] lerp_q16(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b,
                                            logic [EASE_W-1:0] s);
            logic [63:0] n;
            logic [63:0] r;
            n = 64'(a) * (64'd65536 - 64'(s)) + 64'(b) * 64'(s);
            r = (n + 64'd32768) >> 16;
            return (r > 64'd65535) ? 16'hFFFF : VAL_W'(r);
        endfunction

        function void note_item(cmd_t c, logic [TABLE_AW-1:0] idx,
                                logic [VAL_W-1:0] val, logic [31:0] px,
                                logic [31:0] py);
            logic [VAL_W-1:0]  c00;
            logic [VAL_W-1:0]  c10;
            logic [VAL_W-1:0]  c01;
            logic [VAL_W-1:0]  c11;
            logic [VAL_W-1:0]  n0;
            logic [VAL_W-1:0]  n1;
            logic [EASE_W-1:0] sx;
            logic [EASE_W-1:0] sy;
            if (c == CMD_WRITE) begin
                lattice[idx] = val;
                written[idx] = 1'b1;
                return;
            end
            c00 = lattice[corner_addr(px, py, 0)];
            c10 = lattice[corner_addr(px, py, 1)];
            c01 = lattice[corner_addr(px, py, 2)];
            c11 = lattice[corner_addr(px, py, 3)];
            sx  = ease_frac(px[FRAC_W-1:0]);
            sy  = ease_frac(py[FRAC_W-1:0]);
            n0  = lerp_q16(c00, c10, sx);
            n1  = lerp_q16(c01, c11, sx);
            expected_noise.push_back(lerp_q16(n0, n1, sy));
        endfunction

        function void check_noise(logic [VAL_W-1:0] actual);
            logic [VAL_W-1:0] exp_val;
            if (expected_noise.size() == 0) begin
                errors++;
                $display("%0t: unexpected noise transaction, expected none, actual %0d",
                         $time, actual);
                return;
            end
            exp_val = expected_noise.pop_front();
            if (actual !== exp_val) begin
                errors++;
                $display("%0t: noise_value mismatch, expected %0d, actual %0d",
                         $time, exp_val, actual);
            end
        endfunction

        function int pending();
            return expected_noise.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and dut signals
    // ------------------------------------------------------------------------
    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      item_valid  = 1'b0;
    logic                      item_ready;
    cmd_t                      item_cmd    = CMD_WRITE;
    logic [TABLE_AW-1:0]       entry_index = '0;
    logic [VAL_W-1:0]          entry_value = '0;
    logic signed [POINT_W-1:0] point_x     = '0;
    logic signed [POINT_W-1:0] point_y     = '0;
    logic                      noise_valid;
    logic                      noise_ready = 1'b0;
    logic [VAL_W-1:0]          noise_value;

    noise_scoreboard noise_sb = new();

    // idle rates in percent, changed between phases
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int sent_count     = 0;

    always #5 clk = ~clk;

    value_noise_2d #(
        .GRID_SIDE(GRID)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .cmd        (item_cmd),
        .entry_index(entry_index),
        .entry_value(entry_value),
        .point_x    (point_x),
        .point_y    (point_y),
        .noise_valid(noise_valid),
        .noise_ready(noise_ready),
        .noise_value(noise_value)
    );

    // ------------------------------------------------------------------------
    // result side: check the transaction taken at this edge, then pick the
    // ready level for the next cycle
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            noise_ready <= 1'b0;
        end
        else begin
            if (noise_valid && noise_ready)
                noise_sb.check_noise(noise_value);
            noise_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // item side
    // ------------------------------------------------------------------------
    // one transaction; returns in the time step of the accepting edge with
    // valid still high, so the next call can keep it high without a glitch
    task automatic send_item(cmd_t c, logic [TABLE_AW-1:0] idx, logic [VAL_W-1:0] val,
                             logic [31:0] px, logic [31:0] py);
        while ($urandom_range(99) < send_idle_pct) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid  <= 1'b1;
        item_cmd    <= c;
        entry_index <= idx;
        entry_value <= val;
        point_x     <= px;
        point_y     <= py;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        noise_sb.note_item(c, idx, val, px, py);
        sent_count++;
    endtask

    // evaluate a point, first filling any corner of its cell not yet written
    task automatic eval_point(logic [31:0] px, logic [31:0] py,
                              logic [TABLE_AW-1:0] idx_junk, logic [VAL_W-1:0] val_junk);
        logic [TABLE_AW-1:0] addr;
        for (int k = 0; k < 4; k++) begin
            addr = noise_sb.corner_addr(px, py, k);
            if (!noise_sb.written[addr])
                send_item(CMD_WRITE, addr, VAL_W'($urandom), $urandom, $urandom);
        end
        send_item(CMD_EVAL, idx_junk, val_junk, px, py);
    endtask

    // drop valid and wait until the pipeline has delivered everything
    task automatic drain_results();
        item_valid <= 1'b0;
        do @(posedge clk); while (noise_sb.pending() != 0);
    endtask

    // coordinate with a random integer part and a mix of fraction shapes
    function automatic logic [31:0] rand_coord();
        logic [15:0] ip;
        logic [15:0] fr;
        ip = 16'($urandom);
        fr = 16'($urandom);
        case ($urandom_range(3))
            0: begin
                // fraction at an edge of its range, just above zero, or at one half
                case ($urandom_range(3))
                    0: fr = 16'h0000;
                    1: fr = 16'hFFFF;
                    2: fr = 16'h8000;
                    default: fr = 16'h0001;
                endcase
            end
            // near the origin, so that written cells are visited again
            1: ip = 16'($urandom_range(7)) - 16'd4;
            default: ;
        endcase
        return {ip, fr};
    endfunction

    task automatic run_random(int n_items);
        int target;
        target = sent_count + n_items;
        while (sent_count < target) begin
            if ($urandom_range(99) < 25)
                send_item(CMD_WRITE, TABLE_AW'($urandom), VAL_W'($urandom),
                          $urandom, $urandom);
            else
                eval_point(rand_coord(), rand_coord(), TABLE_AW'($urandom),
                           VAL_W'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: value and index extremes, point fields ignored on writes
        send_item(CMD_WRITE, 16'd0,     16'd0,     32'hFFFF_FFFF, 32'h8000_0000);
        send_item(CMD_WRITE, 16'd1,     16'hFFFF,  32'h0,         32'h0);
        send_item(CMD_WRITE, 16'd256,   16'h8000,  32'h0,         32'h0);
        send_item(CMD_WRITE, 16'd257,   16'h1234,  32'h0,         32'h0);
        send_item(CMD_WRITE, 16'hFFFF,  16'hFFFF,  32'h0,         32'h0);
        send_item(CMD_WRITE, 16'hFF00,  16'd0,     32'h0,         32'h0);
        send_item(CMD_WRITE, 16'd255,   16'd1,     32'h0,         32'h0);
        // origin, fraction extremes, one half and quarters; index and value ignored
        eval_point(32'h0000_0000, 32'h0000_0000, 16'h0,    16'h0);
        eval_point(32'h0000_FFFF, 32'h0000_FFFF, 16'hFFFF, 16'hFFFF);
        eval_point(32'h0000_8000, 32'h0000_8000, 16'hFFFF, 16'h0);
        eval_point(32'h0000_4000, 32'h0000_C000, 16'h0,    16'hFFFF);
        // negative coordinates floor toward minus infinity; extreme ones wrap
        eval_point(32'hFFFF_0000, 32'hFFFF_0000, 16'h0,    16'h0);
        eval_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0,    16'h0);
        eval_point(32'h8000_0000, 32'h8000_0000, 16'h0,    16'h0);
        eval_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0,    16'h0);
        eval_point(32'h8000_0000, 32'h7FFF_FFFF, 16'h0,    16'h0);
        // a write directly followed by an evaluate that reads it
        send_item(CMD_WRITE, 16'd0, 16'd12345, 32'h0, 32'h0);
        eval_point(32'h0000_0000, 32'h0000_0000, 16'h0, 16'h0);
        send_item(CMD_WRITE, 16'd257, 16'hFFFF, 32'h0, 32'h0);
        eval_point(32'h0000_FFFF, 32'h0000_FFFF, 16'h0, 16'h0);

        // random phases: no idling, sender idle, receiver stalling, both
        run_random(460);
        send_idle_pct = 69;
        run_random(460);

        // sender holds off until the pipeline is empty
        drain_results();

        send_idle_pct  = 0;
        recv_stall_pct = 69;
        run_random(460);
        send_idle_pct  = 10;
        recv_stall_pct = 10;
        run_random(460);

        drain_results();
        repeat (20) @(posedge clk);

        if (noise_sb.errors == 0 && noise_sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog for a hung handshake
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

/* files.f */
rtl/core/vn2_pkg.sv
rtl/core/vn2_wrap.sv
rtl/core/vn2_ease.sv
rtl/core/vn2_lerp.sv
rtl/core/vn2_lattice.sv
rtl/core/value_noise_2d.sv
tb/sv/testbench.sv
